// ----- src/tkh_pkg.sv -----
// Shared types, widths and codes for the top-k keyed min-heap.
`default_nettype none
package tkh_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned WeightW  = 48;
  localparam int unsigned CfgW     = 6;

  // Opcodes
  localparam logic [2:0] OpAddWeight = 3'd0;
  localparam logic [2:0] OpInsertNew = 3'd1;
  localparam logic [2:0] OpReplace   = 3'd2;
  localparam logic [2:0] OpPeek      = 3'd3;
  localparam logic [2:0] OpDump      = 3'd4;
  localparam logic [2:0] OpClear     = 3'd5;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StDup      = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0]           key;
    logic signed [WeightW-1:0] weight;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/tkh_ram.sv -----
// Single write port, single registered read port heap slot store.
`default_nettype none
module tkh_ram
  import tkh_pkg::*;
(
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  wire entry_t      wdata_i,
  input  wire              re_i,
  input  wire [AddrW-1:0]  raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Capacity];
  entry_t rdata_q;

  // Write slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read slot, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- src/tkh_alu.sv -----
// Shared weight unit: saturating add and signed less-than compare.
`default_nettype none
module tkh_alu
  import tkh_pkg::*;
(
  input  wire signed [WeightW-1:0] a_i,
  input  wire signed [WeightW-1:0] b_i,
  output logic signed [WeightW-1:0] sum_o,
  output logic                      lt_o
);

  logic signed [WeightW:0] wide;

  // Add with one guard bit, clamp on overflow
  always_comb begin
    wide = {a_i[WeightW-1], a_i} + {b_i[WeightW-1], b_i};
    if (wide[WeightW] != wide[WeightW-1]) begin
      sum_o = wide[WeightW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
    end else begin
      sum_o = wide[WeightW-1:0];
    end
    lt_o = (a_i < b_i);
  end

endmodule
`default_nettype wire

// ----- src/top_k_keyed_min_heap_top.sv -----
// Top level: heap sequencer with key scan, sift, heapsort dump and result register.
// Sequence: a key scan reads the held slots in turn, then a sift walks one heap level
// at a time going up or down over the one read port; a dump is a heapsort followed by
// one beat per held slot and a swap of each mirrored slot pair.
// Throughput: one item at a time; input stalls until the op finishes.
// Reset: held count zero, capacity 32, no result pending; slot contents undefined.
`default_nettype none
module top_k_keyed_min_heap_top
  import tkh_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [CfgW-1:0]           cfg_wdata_i,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire [2:0]                opcode_i,
  input  wire [KeyW-1:0]           item_key_i,
  input  wire signed [WeightW-1:0] item_weight_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [2:0]               status_o,
  output logic [KeyW-1:0]          out_key_o,
  output logic signed [WeightW-1:0] out_weight_o,
  output logic [CntW-1:0]          entry_count_o,
  output logic                     last_o
);

  localparam logic [4:0] SIdle = 5'd0,  SScan = 5'd1,  SHit  = 5'd2,  SMiss = 5'd3;
  localparam logic [4:0] SRd0  = 5'd4,  SUp   = 5'd5,  SUpC  = 5'd6,  SDn   = 5'd7;
  localparam logic [4:0] SDc1  = 5'd8,  SDc2  = 5'd9,  SDcmp = 5'd10, SFin  = 5'd11;
  localparam logic [4:0] SEmit = 5'd12, SHs   = 5'd13, SHsR0 = 5'd14, SHsRn = 5'd15;
  localparam logic [4:0] SDRd  = 5'd16, SDOut = 5'd17, SRev  = 5'd18, SRevA = 5'd19;
  localparam logic [4:0] SRevB = 5'd20, SRevC = 5'd21;

  logic [4:0]      state_q, state_d;
  logic [CfgW-1:0] cap_q, cap_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ov_q, ov_d;
  logic [2:0]      op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic signed [WeightW-1:0] w_q, w_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            first_q, first_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] h_q, h_d;
  logic [AddrW-1:0] cidx_q, cidx_d;
  logic [CntW-1:0] sn_q, sn_d;
  logic [CntW-1:0] n_q, n_d;
  entry_t          mv_q, mv_d;
  entry_t          cd_q, cd_d;
  logic [2:0]      rst_q, rst_d;
  entry_t          rep_q, rep_d;
  logic [2:0]      ost_q, ost_d;
  entry_t          oent_q, oent_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic            olast_q, olast_d;

  logic            we, re;
  logic [AddrW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic signed [WeightW-1:0] alu_a, alu_b, alu_sum;
  logic            alu_lt;

  logic            in_acc, out_free;
  logic [CntW-1:0] eff_cap;
  logic [CntW:0]   child, child2;
  logic [AddrW-1:0] parent;
  logic [CntW-1:0] rev_j;

  tkh_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tkh_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // Clamp the capacity register
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (CntW'(cap_q) > CntW'(Capacity)) begin
      eff_cap = CntW'(Capacity);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  assign child  = {1'b0, h_q, 1'b1};
  assign child2 = {1'b0, CntW'(cidx_q)} + (CntW+1)'(1);
  assign parent = AddrW'((h_q - AddrW'(1)) >> 1);
  assign rev_j  = cnt_q - CntW'(1) - idx_q;

  // Steer the shared unit
  always_comb begin
    case (state_q)
      SHit: begin
        alu_a = rdata.weight;
        alu_b = w_q;
      end
      SDc2: begin
        alu_a = rdata.weight;
        alu_b = cd_q.weight;
      end
      SDcmp: begin
        alu_a = mv_q.weight;
        alu_b = cd_q.weight;
      end
      default: begin
        alu_a = mv_q.weight;
        alu_b = rdata.weight;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cap_d   = cfg_we_i ? cfg_wdata_i : cap_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    key_d   = key_q;
    w_d     = w_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    first_d = first_q;
    pos_d   = pos_q;
    h_d     = h_q;
    cidx_d  = cidx_q;
    sn_d    = sn_q;
    n_d     = n_q;
    mv_d    = mv_q;
    cd_d    = cd_q;
    rst_d   = rst_q;
    rep_d   = rep_q;
    ost_d   = ost_q;
    oent_d  = oent_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;
    ov_d    = ov_q && out_stall_i;
    we      = 1'b0;
    waddr   = h_q;
    wdata   = mv_q;
    re      = 1'b0;
    raddr   = '0;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          op_d    = opcode_i;
          key_d   = item_key_i;
          w_d     = item_weight_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          first_d = 1'b0;
          sn_d    = cnt_q;
          rst_d   = StOk;
          rep_d   = '0;
          case (opcode_i)
            OpAddWeight, OpInsertNew: begin
              state_d = SScan;
            end
            OpReplace: begin
              if (cnt_q == '0) begin
                rst_d   = StEmpty;
                state_d = SEmit;
              end else begin
                state_d = SScan;
              end
            end
            OpPeek: begin
              if (cnt_q == '0) begin
                rst_d   = StEmpty;
                state_d = SEmit;
              end else begin
                re      = 1'b1;
                state_d = SRd0;
              end
            end
            OpDump: begin
              if (cnt_q == '0) begin
                rst_d   = StEmpty;
                state_d = SEmit;
              end else begin
                n_d     = cnt_q;
                state_d = SHs;
              end
            end
            OpClear: begin
              cnt_d   = '0;
              state_d = SEmit;
            end
            default: begin
              state_d = SEmit;
            end
          endcase
        end
      end

      // Walk the slots, one read in flight
      SScan: begin
        if (pend_q && rdata.key == key_q) begin
          pos_d   = AddrW'(idx_q - CntW'(1));
          state_d = SHit;
        end else if (idx_q == cnt_q) begin
          state_d = SMiss;
        end else begin
          re     = 1'b1;
          raddr  = idx_q[AddrW-1:0];
          idx_d  = idx_q + CntW'(1);
          pend_d = 1'b1;
        end
      end

      SHit: begin
        case (op_q)
          OpAddWeight: begin
            mv_d    = '{key: key_q, weight: alu_sum};
            rep_d   = '{key: key_q, weight: alu_sum};
            h_d     = pos_q;
            first_d = 1'b1;
            state_d = SUp;
          end
          OpReplace: begin
            if (pos_q != '0) begin
              rst_d   = StDup;
              rep_d   = '{key: key_q, weight: rdata.weight};
              state_d = SEmit;
            end else begin
              rep_d   = rdata;
              mv_d    = '{key: key_q, weight: w_q};
              h_d     = '0;
              state_d = SDn;
            end
          end
          default: begin
            rst_d   = StDup;
            rep_d   = '{key: key_q, weight: rdata.weight};
            state_d = SEmit;
          end
        endcase
      end

      SMiss: begin
        case (op_q)
          OpInsertNew: begin
            if (cnt_q >= eff_cap) begin
              rst_d   = StFull;
              state_d = SEmit;
            end else begin
              h_d     = cnt_q[AddrW-1:0];
              cnt_d   = cnt_q + CntW'(1);
              mv_d    = '{key: key_q, weight: w_q};
              rep_d   = '{key: key_q, weight: w_q};
              state_d = SUp;
            end
          end
          OpReplace: begin
            re      = 1'b1;
            state_d = SRd0;
          end
          default: begin
            rst_d   = StNotFound;
            state_d = SEmit;
          end
        endcase
      end

      SRd0: begin
        rep_d = rdata;
        if (op_q == OpReplace) begin
          mv_d    = '{key: key_q, weight: w_q};
          h_d     = '0;
          state_d = SDn;
        end else begin
          state_d = SEmit;
        end
      end

      // Sift up: fetch parent
      SUp: begin
        if (h_q == '0) begin
          if (first_q) begin
            first_d = 1'b0;
            state_d = SDn;
          end else begin
            we      = 1'b1;
            state_d = SFin;
          end
        end else begin
          re      = 1'b1;
          raddr   = parent;
          state_d = SUpC;
        end
      end

      SUpC: begin
        if (!alu_lt) begin
          if (first_q) begin
            first_d = 1'b0;
            state_d = SDn;
          end else begin
            we      = 1'b1;
            state_d = SFin;
          end
        end else begin
          we      = 1'b1;
          wdata   = rdata;
          h_d     = parent;
          first_d = 1'b0;
          state_d = SUp;
        end
      end

      // Sift down: fetch left child
      SDn: begin
        if (child >= {1'b0, sn_q}) begin
          we      = 1'b1;
          state_d = SFin;
        end else begin
          re      = 1'b1;
          raddr   = child[AddrW-1:0];
          cidx_d  = child[AddrW-1:0];
          state_d = SDc1;
        end
      end

      SDc1: begin
        cd_d = rdata;
        if (child2 < {1'b0, sn_q}) begin
          re      = 1'b1;
          raddr   = child2[AddrW-1:0];
          state_d = SDc2;
        end else begin
          state_d = SDcmp;
        end
      end

      SDc2: begin
        if (alu_lt) begin
          cd_d   = rdata;
          cidx_d = child2[AddrW-1:0];
        end
        state_d = SDcmp;
      end

      SDcmp: begin
        we = 1'b1;
        if (alu_lt) begin
          state_d = SFin;
        end else begin
          wdata   = cd_q;
          h_d     = cidx_q;
          state_d = SDn;
        end
      end

      SFin: begin
        state_d = (op_q == OpDump) ? SHs : SEmit;
      end

      // Heapsort: swap root with last live slot
      SHs: begin
        if (n_q == CntW'(1)) begin
          idx_d   = '0;
          state_d = SDRd;
        end else begin
          n_d     = n_q - CntW'(1);
          re      = 1'b1;
          state_d = SHsR0;
        end
      end

      SHsR0: begin
        we      = 1'b1;
        waddr   = n_q[AddrW-1:0];
        wdata   = rdata;
        re      = 1'b1;
        raddr   = n_q[AddrW-1:0];
        state_d = SHsRn;
      end

      SHsRn: begin
        mv_d    = rdata;
        h_d     = '0;
        sn_d    = n_q;
        state_d = SDn;
      end

      // Emit dump beats in slot order
      SDRd: begin
        re      = 1'b1;
        raddr   = idx_q[AddrW-1:0];
        state_d = SDOut;
      end

      SDOut: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = StOk;
          oent_d  = rdata;
          ocnt_d  = cnt_q;
          olast_d = (idx_q == cnt_q - CntW'(1));
          if (idx_q == cnt_q - CntW'(1)) begin
            idx_d   = '0;
            state_d = SRev;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = SDRd;
          end
        end
      end

      // Reverse into ascending order
      SRev: begin
        if (idx_q >= (cnt_q >> 1)) begin
          state_d = SIdle;
        end else begin
          re      = 1'b1;
          raddr   = idx_q[AddrW-1:0];
          state_d = SRevA;
        end
      end

      SRevA: begin
        cd_d    = rdata;
        re      = 1'b1;
        raddr   = rev_j[AddrW-1:0];
        state_d = SRevB;
      end

      SRevB: begin
        we      = 1'b1;
        waddr   = idx_q[AddrW-1:0];
        wdata   = rdata;
        state_d = SRevC;
      end

      SRevC: begin
        we      = 1'b1;
        waddr   = rev_j[AddrW-1:0];
        wdata   = cd_q;
        idx_d   = idx_q + CntW'(1);
        state_d = SRev;
      end

      // Single-beat result
      SEmit: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = rst_q;
          oent_d  = rep_q;
          ocnt_d  = cnt_q;
          olast_d = 1'b1;
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cap_q   <= CfgW'(Capacity);
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    w_q     <= w_d;
    idx_q   <= idx_d;
    pend_q  <= pend_d;
    first_q <= first_d;
    pos_q   <= pos_d;
    h_q     <= h_d;
    cidx_q  <= cidx_d;
    sn_q    <= sn_d;
    n_q     <= n_d;
    mv_q    <= mv_d;
    cd_q    <= cd_d;
    rst_q   <= rst_d;
    rep_q   <= rep_d;
    ost_q   <= ost_d;
    oent_q  <= oent_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign out_key_o     = oent_q.key;
  assign out_weight_o  = oent_q.weight;
  assign entry_count_o = ocnt_q;
  assign last_o        = olast_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("held count above capacity");

  a_sift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDn) |-> (CntW'(h_q) < sn_q))
    else $error("sift position outside live heap");

  a_clear_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OpClear) |=> (cnt_q == '0))
    else $error("clear left entries held");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q)
    else $error("pending result dropped");
`endif

endmodule
`default_nettype wire
